// ===== rtl/indexed_neighbour_weighted_sum_assert.svh =====
// Assertion macros used by the checker file of this block.
`ifndef INDEXED_NEIGHBOUR_WEIGHTED_SUM_ASSERT_SVH
`define INDEXED_NEIGHBOUR_WEIGHTED_SUM_ASSERT_SVH

// Same-cycle implication: whenever a holds, c holds too.
`define INWS_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("same-cycle implication failed");

// Next-cycle implication: whenever a holds, c holds in the next cycle.
`define INWS_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle implication failed");

// Reset check: while reset is asserted, c holds in the next cycle.
`define INWS_ASSERT_RST(lbl, clk, rst, c) \
  lbl: assert property (@(posedge clk) (rst) |=> (c)) \
    else $error("reset check failed");

`endif

// ===== rtl/inws_pkg.sv =====
// Shared types, codes and constants of the indexed neighbour weighted sum.
package inws_pkg;

  // Command codes of an input item.
  localparam logic [1:0] CMD_LOAD_FEATURE = 2'd0;
  localparam logic [1:0] CMD_LOAD_INDEX   = 2'd1;
  localparam logic [1:0] CMD_LOAD_WEIGHT  = 2'd2;
  localparam logic [1:0] CMD_COMPUTE      = 2'd3;

  // Result error codes.
  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_NEIGHBOUR = 2'd1;
  localparam logic [1:0] ERR_ADDRESS   = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_PIXELS        = 3'd0;
  localparam logic [2:0] REG_CHANNELS      = 3'd1;
  localparam logic [2:0] REG_IMAGES        = 3'd2;
  localparam logic [2:0] REG_NEIGHBOURS    = 3'd3;
  localparam logic [2:0] REG_SHARE_CHANNEL = 3'd4;
  localparam logic [2:0] REG_SHARE_PIXEL   = 3'd5;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;
  localparam int SUM_W       = 40;
  // Wide enough for the largest address the element ranges can form.
  localparam int ADDR_W      = 42;

  // Default sizes.
  localparam int FEATURE_WORDS_DEF  = 65536;
  localparam int INDEX_WORDS_DEF    = 65536;
  localparam int WEIGHT_WORDS_DEF   = 65536;
  localparam int MAX_NEIGHBOURS_DEF = 16;

  // One input item as it waits in the queue.
  typedef struct packed {
    logic [1:0]         cmd;
    logic [15:0]        load_address;
    logic signed [15:0] load_value;
    logic [15:0]        load_neighbour;
    logic [15:0]        pixel;
    logic [7:0]         channel;
    logic [7:0]         image;
  } item_t;

  // Configuration register set.
  typedef struct packed {
    logic [16:0] pixels_per_image;
    logic [8:0]  channel_count;
    logic [8:0]  image_count;
    logic [4:0]  neighbour_count;
    logic        share_across_channels;
    logic        share_across_pixels;
  } cfg_t;

  // Queue head status toward the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  // Back end sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP1,
    ST_SETUP2,
    ST_SETUP3,
    ST_IDX,
    ST_NBR,
    ST_FETCH,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/inws_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module inws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/inws_front.sv =====
// Front end: accepts items and holds them in a two-entry queue.
module inws_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  inws_pkg::item_t in_item,
  input  logic           pop,
  output inws_pkg::head_t head
);
  import inws_pkg::*;

  item_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       do_pop;

  assign busy   = (count == 2'd2);
  assign push   = start && !busy;
  assign do_pop = pop && (count != 2'd0);

  assign head.valid = (count != 2'd0);
  assign head.item  = q[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(do_pop);
    end
  end

endmodule

// ===== rtl/inws_back.sv =====
// Back end: executes loads and runs the neighbour sum sequencer.
module inws_back #(
  parameter int FEATURE_WORDS  = inws_pkg::FEATURE_WORDS_DEF,
  parameter int INDEX_WORDS    = inws_pkg::INDEX_WORDS_DEF,
  parameter int WEIGHT_WORDS   = inws_pkg::WEIGHT_WORDS_DEF,
  parameter int MAX_NEIGHBOURS = inws_pkg::MAX_NEIGHBOURS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  inws_pkg::cfg_t                         cfg,
  input  inws_pkg::head_t                        head,
  output logic                                   pop,
  output logic                                   done,
  output logic signed [inws_pkg::SUM_W-1:0]      weighted_sum,
  output logic [1:0]                             error_code
);
  import inws_pkg::*;

  localparam int FAW = $clog2(FEATURE_WORDS);
  localparam int IAW = $clog2(INDEX_WORDS);
  localparam int WAW = $clog2(WEIGHT_WORDS);
  localparam logic [6:0] MAXN = 7'(MAX_NEIGHBOURS);

  state_t state, state_next;

  item_t              cur;
  logic [24:0]        hw_img;
  logic [24:0]        chan_hw;
  logic [25:0]        hwd;
  logic [33:0]        hwd_img;
  logic [ADDR_W-1:0]  ia;
  logic [ADDR_W-1:0]  fa_base;
  logic [ADDR_W-1:0]  fa;
  logic [ADDR_W-1:0]  wa;
  logic [ADDR_W-1:0]  wa00;
  logic [ADDR_W-1:0]  wa01;
  logic [4:0]         r;
  logic signed [31:0] prod;
  logic signed [SUM_W-1:0] sum;
  logic [1:0]         code, code_next;

  logic [4:0]  nb_eff;
  logic        bad_elem;
  logic        is_load;
  logic [15:0] idx_rdata;
  logic [15:0] feat_rdata;
  logic [15:0] wt_rdata;
  logic        feat_we, idx_we, wt_we;
  logic [ADDR_W-1:0] ld_addr;
  logic [ADDR_W-1:0] wa_sel;

  // Effective neighbour count, limited to the supported maximum.
  assign nb_eff = ({2'b00, cfg.neighbour_count} > MAXN) ? 5'(MAXN) : cfg.neighbour_count;

  assign bad_elem = ({1'b0, cur.pixel} >= cfg.pixels_per_image)
                 || ({1'b0, cur.channel} >= cfg.channel_count)
                 || ({1'b0, cur.image} >= cfg.image_count);

  // Load writes happen as the item leaves the queue.
  assign is_load = (state == ST_IDLE) && head.valid && (head.item.cmd != CMD_COMPUTE);
  assign ld_addr = ADDR_W'(head.item.load_address);
  assign feat_we = is_load && (head.item.cmd == CMD_LOAD_FEATURE)
                && (ld_addr < ADDR_W'(FEATURE_WORDS));
  assign idx_we  = is_load && (head.item.cmd == CMD_LOAD_INDEX)
                && (ld_addr < ADDR_W'(INDEX_WORDS));
  assign wt_we   = is_load && (head.item.cmd == CMD_LOAD_WEIGHT)
                && (ld_addr < ADDR_W'(WEIGHT_WORDS));

  // Weight address by sharing mode; per-pixel sharing of channels equals the index address.
  always_comb begin
    unique case ({cfg.share_across_channels, cfg.share_across_pixels})
      2'b00:   wa_sel = wa00;
      2'b10:   wa_sel = ia;
      2'b01:   wa_sel = wa01;
      default: wa_sel = ADDR_W'(r);
    endcase
  end

  inws_ram #(.WIDTH(16), .DEPTH(INDEX_WORDS)) u_idx_ram (
    .clk(clk), .we(idx_we), .waddr(ld_addr[IAW-1:0]), .wdata(head.item.load_neighbour),
    .raddr(ia[IAW-1:0]), .rdata(idx_rdata)
  );

  inws_ram #(.WIDTH(16), .DEPTH(FEATURE_WORDS)) u_feat_ram (
    .clk(clk), .we(feat_we), .waddr(ld_addr[FAW-1:0]), .wdata(head.item.load_value),
    .raddr(fa[FAW-1:0]), .rdata(feat_rdata)
  );

  inws_ram #(.WIDTH(16), .DEPTH(WEIGHT_WORDS)) u_wt_ram (
    .clk(clk), .we(wt_we), .waddr(ld_addr[WAW-1:0]), .wdata(head.item.load_value),
    .raddr(wa[WAW-1:0]), .rdata(wt_rdata)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, error checks and queue pop.
  always_comb begin
    state_next = state;
    code_next  = code;
    pop        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.item.cmd == CMD_COMPUTE) begin
            state_next = ST_SETUP1;
          end
        end
      end
      ST_SETUP1: begin
        code_next = ERR_OK;
        if (bad_elem) begin
          code_next  = ERR_ADDRESS;
          state_next = ST_DONE;
        end else if (nb_eff == 5'd0) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SETUP2;
        end
      end
      ST_SETUP2: state_next = ST_SETUP3;
      ST_SETUP3: state_next = ST_IDX;
      ST_IDX: begin
        if (ia >= ADDR_W'(INDEX_WORDS)) begin
          code_next  = ERR_ADDRESS;
          state_next = ST_DONE;
        end else begin
          state_next = ST_NBR;
        end
      end
      ST_NBR: begin
        if ({1'b0, idx_rdata} >= cfg.pixels_per_image) begin
          code_next  = ERR_NEIGHBOUR;
          state_next = ST_DONE;
        end else begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (fa >= ADDR_W'(FEATURE_WORDS) || wa >= ADDR_W'(WEIGHT_WORDS)) begin
          code_next  = ERR_ADDRESS;
          state_next = ST_DONE;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_ACC;
      ST_ACC: begin
        state_next = (r + 5'd1 == nb_eff) ? ST_DONE : ST_IDX;
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath registers, updated per sequencer step.
  always_ff @(posedge clk) begin
    code <= code_next;
    unique case (state)
      ST_IDLE: begin
        cur <= head.item;
      end
      ST_SETUP1: begin
        hw_img  <= 25'(cur.image * cfg.pixels_per_image);
        chan_hw <= 25'(cur.channel * cfg.pixels_per_image);
        hwd     <= 26'(cfg.pixels_per_image * cfg.channel_count);
        r       <= 5'd0;
        sum     <= '0;
      end
      ST_SETUP2: begin
        ia      <= ADDR_W'(cur.pixel) + ADDR_W'(hw_img * nb_eff);
        fa_base <= ADDR_W'(chan_hw) + ADDR_W'(hw_img * cfg.channel_count);
        hwd_img <= 34'(hw_img * cfg.channel_count);
        wa01    <= ADDR_W'(cur.channel);
      end
      ST_SETUP3: begin
        wa00 <= ADDR_W'(cur.pixel) + ADDR_W'(chan_hw) + ADDR_W'(hwd_img * nb_eff);
      end
      ST_NBR: begin
        fa <= fa_base + ADDR_W'(idx_rdata);
        wa <= wa_sel;
      end
      ST_MUL: begin
        prod <= $signed(feat_rdata) * $signed(wt_rdata);
      end
      ST_ACC: begin
        sum  <= sum + SUM_W'(prod);
        r    <= r + 5'd1;
        ia   <= ia + ADDR_W'(cfg.pixels_per_image);
        wa00 <= wa00 + ADDR_W'(hwd);
        wa01 <= wa01 + ADDR_W'(cfg.channel_count);
      end
      default: begin
      end
    endcase
  end

  // Result register: one strobe per compute item.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_DONE);
    end
    if (state == ST_DONE) begin
      weighted_sum <= (code == ERR_OK) ? sum : '0;
      error_code   <= code;
    end
  end

endmodule

// ===== rtl/indexed_neighbour_weighted_sum.sv =====
// Load items are written as they leave the queue; a compute item runs the setup steps and
// then, per neighbour, the five-step loop (index read, neighbour check, feature and weight
// read, multiply, accumulate) around registered single-read-port RAMs, before its result strobe.
// A two-entry queue accepts items while the back end works; busy means the queue is full.
// The done strobe lasts one cycle and cannot be held off.
// Synchronous reset empties the queue, idles the sequencer, clears done and restores the configuration registers.
module indexed_neighbour_weighted_sum #(
  parameter int FEATURE_WORDS  = inws_pkg::FEATURE_WORDS_DEF,
  parameter int INDEX_WORDS    = inws_pkg::INDEX_WORDS_DEF,
  parameter int WEIGHT_WORDS   = inws_pkg::WEIGHT_WORDS_DEF,
  parameter int MAX_NEIGHBOURS = inws_pkg::MAX_NEIGHBOURS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             cmd,
  input  logic [15:0]                            load_address,
  input  logic signed [15:0]                     load_value,
  input  logic [15:0]                            load_neighbour,
  input  logic [15:0]                            pixel,
  input  logic [7:0]                             channel,
  input  logic [7:0]                             image,
  input  logic                                   cfg_write,
  input  logic [inws_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [inws_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic                                   done,
  output logic signed [inws_pkg::SUM_W-1:0]      weighted_sum,
  output logic [1:0]                             error_code
);
  import inws_pkg::*;

  cfg_t  cfg;
  item_t in_item;
  head_t head;
  logic  pop;

  assign in_item.cmd            = cmd;
  assign in_item.load_address   = load_address;
  assign in_item.load_value     = load_value;
  assign in_item.load_neighbour = load_neighbour;
  assign in_item.pixel          = pixel;
  assign in_item.channel        = channel;
  assign in_item.image          = image;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixels_per_image      <= 17'd1;
      cfg.channel_count         <= 9'd1;
      cfg.image_count           <= 9'd1;
      cfg.neighbour_count       <= 5'd1;
      cfg.share_across_channels <= 1'b0;
      cfg.share_across_pixels   <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PIXELS:        cfg.pixels_per_image      <= cfg_data;
        REG_CHANNELS:      cfg.channel_count         <= cfg_data[8:0];
        REG_IMAGES:        cfg.image_count           <= cfg_data[8:0];
        REG_NEIGHBOURS:    cfg.neighbour_count       <= cfg_data[4:0];
        REG_SHARE_CHANNEL: cfg.share_across_channels <= cfg_data[0];
        REG_SHARE_PIXEL:   cfg.share_across_pixels   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  inws_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_item(in_item), .pop(pop), .head(head)
  );

  inws_back #(
    .FEATURE_WORDS(FEATURE_WORDS), .INDEX_WORDS(INDEX_WORDS),
    .WEIGHT_WORDS(WEIGHT_WORDS), .MAX_NEIGHBOURS(MAX_NEIGHBOURS)
  ) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .head(head), .pop(pop),
    .done(done), .weighted_sum(weighted_sum), .error_code(error_code)
  );

endmodule

// ===== rtl/inws_checker.sv =====
// Port-level checks of the block and their binding to the top level.
`include "indexed_neighbour_weighted_sum_assert.svh"

module inws_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   busy,
  input logic                                   done,
  input logic signed [inws_pkg::SUM_W-1:0]      weighted_sum,
  input logic [1:0]                             error_code
);
  import inws_pkg::*;

  // A failed item carries a zero sum.
  `INWS_ASSERT_IMP(a_err_zero, clk, rst, done && (error_code != ERR_OK), weighted_sum == '0)
  // Only defined codes appear on a result.
  `INWS_ASSERT_IMP(a_code_ok, clk, rst, done, error_code <= ERR_ADDRESS)
  // A result is never followed by another in the next cycle.
  `INWS_ASSERT_NEXT(a_gap, clk, rst, done, !done)
  // Reset leaves no result and busy low.
  `INWS_ASSERT_RST(a_reset, clk, rst, !done && !busy)

endmodule

bind indexed_neighbour_weighted_sum inws_checker u_inws_checker (.*);
